@@ hw/rtl/lcgrv_pkg.sv @@
package lcgrv_pkg;

	// Number of draws summed for a normal deviate.
	localparam int NORMAL_TERMS = 12;

	localparam logic [31:0] LCG_SEED = 32'd237465;
	localparam logic [31:0] LCG_MUL  = 32'd1103515245;
	localparam logic [31:0] LCG_ADD  = 32'd12345;

	localparam logic [2:0] FUNC_RAW    = 3'd0;
	localparam logic [2:0] FUNC_INT    = 3'd1;
	localparam logic [2:0] FUNC_FIXED  = 3'd2;
	localparam logic [2:0] FUNC_NORMAL = 3'd3;
	localparam logic [2:0] FUNC_RESEED = 3'd4;

	// Draw counter, and the sum of draws with the mean of all terms taken off.
	localparam int CNT_W = (NORMAL_TERMS > 1) ? $clog2(NORMAL_TERMS) : 1;
	localparam int SUM_W = $clog2(NORMAL_TERMS) + 32;
	// Multiplicand holds either the range width (34 bits) or the centred sum.
	localparam int X_W   = (SUM_W > 34) ? SUM_W : 34;
	localparam int P_W   = X_W + 17;
	localparam int ACC_W = X_W + 33;

	typedef enum logic [1:0] {
		RES_ZERO   = 2'd0,
		RES_RAW    = 2'd1,
		RES_SCALED = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     add_one;
		logic     reseed;
		logic     advance;
		logic     add_draw;
		logic     mul;
		logic     mul_hi;
		logic     acc_lo;
		logic     acc_hi;
		logic     sel_sum;
		logic     emit;
		res_sel_t res_sel;
	} cmd_t;

endpackage

@@ hw/rtl/lcgrv_datapath.sv @@
module lcgrv_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  lcgrv_pkg::cmd_t    cmd,
	input  logic signed [31:0] arg_a,
	input  logic signed [31:0] arg_b,
	output logic signed [31:0] value,
	output logic               saturated
);
	import lcgrv_pkg::*;

	localparam int Q_W = ACC_W - 31;
	localparam int R_W = Q_W + 1;
	localparam logic signed [R_W-1:0] VMAX = R_W'(32'sh7fffffff);
	localparam logic signed [R_W-1:0] VMIN = R_W'(32'sh80000000);
	localparam logic signed [SUM_W-1:0] SUM_INIT =
		SUM_W'(-(64'sd1073741824 * NORMAL_TERMS));

	logic [31:0]              lcg_q;
	logic [31:0]              lcg_next;
	logic signed [31:0]       b_q;
	logic signed [33:0]       d_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [P_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0]       value_q;
	logic                     sat_q;

	logic signed [X_W-1:0]    x_sel;
	logic signed [31:0]       y_sel;
	logic signed [16:0]       y_part;
	logic signed [Q_W-1:0]    q;
	logic                     frac_nz;
	logic signed [R_W-1:0]    r;
	logic                     r_hi;
	logic                     r_lo;
	logic signed [31:0]       res_value;
	logic                     res_sat;

	assign lcg_next = lcg_q * LCG_MUL + LCG_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= LCG_SEED;
		end else if (cmd.reseed) begin
			lcg_q <= arg_a;
		end else if (cmd.advance) begin
			lcg_q <= lcg_next;
		end
	end

	// The multiplier word is taken in two 16-bit halves, low half unsigned.
	assign x_sel  = cmd.sel_sum ? X_W'(sum_q) : X_W'(d_q);
	assign y_sel  = cmd.sel_sum ? b_q : {1'b0, lcg_q[30:0]};
	assign y_part = cmd.mul_hi ? {y_sel[31], y_sel[31:16]} : {1'b0, y_sel[15:0]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_q   <= arg_b;
			d_q   <= 34'(arg_b) - 34'(arg_a) + (cmd.add_one ? 34'sd1 : 34'sd0);
			acc_q <= ACC_W'(arg_a) <<< 31;
			sum_q <= SUM_INIT;
		end else begin
			if (cmd.add_draw) begin
				sum_q <= sum_q + SUM_W'({1'b0, lcg_q[30:0]});
			end
			if (cmd.mul) begin
				prod_q <= x_sel * y_part;
			end
			if (cmd.acc_lo) begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end else if (cmd.acc_hi) begin
				acc_q <= acc_q + (ACC_W'(prod_q) <<< 16);
			end
		end
		if (cmd.emit) begin
			value_q <= res_value;
			sat_q   <= res_sat;
		end
	end

	// The accumulator holds the exact result scaled by 2^31; a negative value
	// with a non-zero fraction is rounded up to truncate toward zero.
	assign q       = acc_q[ACC_W-1:31];
	assign frac_nz = |acc_q[30:0];
	assign r       = R_W'(q) + ((acc_q[ACC_W-1] && frac_nz) ? R_W'(1) : R_W'(0));
	assign r_hi    = r > VMAX;
	assign r_lo    = r < VMIN;

	always_comb begin
		res_value = '0;
		res_sat   = 1'b0;
		unique case (cmd.res_sel)
			RES_RAW: begin
				res_value = {1'b0, lcg_q[30:0]};
			end
			RES_SCALED: begin
				res_sat = r_hi || r_lo;
				if (r_hi) begin
					res_value = 32'sh7fffffff;
				end else if (r_lo) begin
					res_value = 32'sh80000000;
				end else begin
					res_value = r[31:0];
				end
			end
			default: begin
				res_value = '0;
			end
		endcase
	end

	assign value     = value_q;
	assign saturated = sat_q;

endmodule

@@ hw/rtl/lcgrv_ctrl.sv @@
module lcgrv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2:0]      func,
	input  logic            out_stall,
	output logic            in_stall,
	output logic            out_valid,
	output lcgrv_pkg::cmd_t cmd
);
	import lcgrv_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_DRAW    = 7'b0000010,
		S_SUMLAST = 7'b0000100,
		S_MULLO   = 7'b0001000,
		S_MULHI   = 7'b0010000,
		S_ACCHI   = 7'b0100000,
		S_FIN     = 7'b1000000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [2:0]       op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             emit;

	assign accept = (state_q == S_IDLE) && in_valid;
	assign emit   = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (func == FUNC_RAW || func == FUNC_INT || func == FUNC_FIXED
					    || func == FUNC_NORMAL) begin
						state_d = S_DRAW;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_DRAW: begin
				if (cnt_q == '0) begin
					if (op_q == FUNC_NORMAL) begin
						state_d = S_SUMLAST;
					end else if (op_q == FUNC_RAW) begin
						state_d = S_FIN;
					end else begin
						state_d = S_MULLO;
					end
				end
			end
			S_SUMLAST: state_d = S_MULLO;
			S_MULLO:   state_d = S_MULHI;
			S_MULHI:   state_d = S_ACCHI;
			S_ACCHI:   state_d = S_FIN;
			S_FIN: begin
				if (emit) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= FUNC_RAW;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q  <= func;
				cnt_q <= (func == FUNC_NORMAL) ? CNT_W'(NORMAL_TERMS - 1) : '0;
			end else if (state_q == S_DRAW && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd.load     = accept;
		cmd.add_one  = (func == FUNC_INT);
		cmd.reseed   = accept && (func == FUNC_RESEED);
		cmd.advance  = (state_q == S_DRAW);
		// The draw made in one cycle is summed in the next one.
		cmd.add_draw = (op_q == FUNC_NORMAL)
		               && (((state_q == S_DRAW) && (cnt_q != CNT_W'(NORMAL_TERMS - 1)))
		                   || (state_q == S_SUMLAST));
		cmd.mul      = (state_q == S_MULLO) || (state_q == S_MULHI);
		cmd.mul_hi   = (state_q == S_MULHI);
		cmd.acc_lo   = (state_q == S_MULHI);
		cmd.acc_hi   = (state_q == S_ACCHI);
		cmd.sel_sum  = (op_q == FUNC_NORMAL);
		cmd.emit     = emit;
		if (op_q == FUNC_RAW) begin
			cmd.res_sel = RES_RAW;
		end else if (op_q == FUNC_INT || op_q == FUNC_FIXED || op_q == FUNC_NORMAL) begin
			cmd.res_sel = RES_SCALED;
		end else begin
			cmd.res_sel = RES_ZERO;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/lcg_random_variate_generator_top.sv @@
// Random variate generator on a 32-bit linear congruential sequence.
// Input channel: in_valid / in_stall carry one request beat (func, arg_a,
// arg_b); output channel: out_valid / out_stall carry one result beat
// (value, saturated) per request, in request order.
// One request is worked on at a time: the block takes the next beat only
// once the result of the last one is in the output register. A request is
// a raw draw, an integer or fixed-point range, a normal deviate, a reseed or
// an unused code. The result is offered in the same cycle as the block is
// ready again. The generator's multiplier makes one draw a cycle, and the
// shared 17-bit-slice multiplier scales a draw or the centred sum in two
// halves.
// Reset loads the seed 237465 and empties the output register.
// The output register holds a result while out_stall is high; the block
// meanwhile accepts and works on the next request and waits with its result
// until the register is free.
module lcg_random_variate_generator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [31:0] arg_a,
	input  logic signed [31:0] arg_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               saturated
);
	import lcgrv_pkg::*;

	cmd_t cmd;

	lcgrv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	lcgrv_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.arg_a     (arg_a),
		.arg_b     (arg_b),
		.value     (value),
		.saturated (saturated)
	);

endmodule

@@ hw/rtl/lcgrv_checker.sv @@
module lcgrv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] value,
	input logic               saturated
);

	// Once a request is taken the block is busy in the cycle after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block took a second request straight after the first");

	// A clipped result sits at one of the two bounds.
	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (value == 32'h7fffffff || value == 32'h80000000))
		else $error("saturated result is not at a bound");

	// An idle block with an empty output cannot produce a result next cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && !out_valid) |=> !out_valid)
		else $error("result beat without a request");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(saturated)))
		else $error("stalled result beat changed");

endmodule

bind lcg_random_variate_generator_top lcgrv_checker u_checker (.*);

@@ test/lcgrv_checker.sv @@
`timescale 1ns / 1ps

module lcgrv_tb_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [31:0] arg_a,
	input  logic signed [31:0] arg_b,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] value,
	input  logic               saturated,
	output int                 fail_count,
	output int                 pending
);
	import lcgrv_pkg::*;

	typedef struct packed {
		logic signed [31:0] value;
		logic               saturated;
	} variate_t;

	localparam logic signed [95:0] FRAC_ONE = 96'sd2147483648;
	localparam logic signed [95:0] HALF_ONE = 96'sd1073741824;
	localparam logic signed [95:0] VAL_MAX  = 96'sd2147483647;
	localparam logic signed [95:0] VAL_MIN  = -(96'sd2147483648);

	variate_t   variate_q[$];
	variate_t   oldest;
	logic [31:0] gen_state;
	int         errors = 0;
	int         outstanding = 0;

	assign fail_count = errors;
	assign pending    = outstanding;

	function automatic logic [30:0] next_draw();
		gen_state = gen_state * LCG_MUL + LCG_ADD;
		return gen_state[30:0];
	endfunction

	// The numerator carries the exact result scaled by 2^31; signed division
	// truncates toward zero, which is the rounding the block must follow.
	function automatic variate_t clip_scaled(logic signed [95:0] num);
		logic signed [95:0] q;
		variate_t r;
		q = num / FRAC_ONE;
		r.saturated = 1'b0;
		if (q > VAL_MAX) begin
			q = VAL_MAX;
			r.saturated = 1'b1;
		end else if (q < VAL_MIN) begin
			q = VAL_MIN;
			r.saturated = 1'b1;
		end
		r.value = q[31:0];
		return r;
	endfunction

	function automatic variate_t predict_variate(logic [2:0] f, logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [95:0] wa;
		logic signed [95:0] wb;
		logic signed [95:0] wd;
		logic signed [95:0] wu;
		logic signed [95:0] sum;
		variate_t r;
		r  = '0;
		wa = a;
		wb = b;
		case (f)
			FUNC_RAW: begin
				r.value = {1'b0, next_draw()};
			end
			FUNC_INT: begin
				wu = {65'd0, next_draw()};
				wd = wb - wa + 96'sd1;
				r  = clip_scaled((wa <<< 31) + wd * wu);
			end
			FUNC_FIXED: begin
				wu = {65'd0, next_draw()};
				wd = wb - wa;
				r  = clip_scaled((wa <<< 31) + wd * wu);
			end
			FUNC_NORMAL: begin
				sum = '0;
				for (int i = 0; i < NORMAL_TERMS; i++) begin
					wu  = {65'd0, next_draw()};
					sum = sum + wu;
				end
				sum = sum - HALF_ONE * NORMAL_TERMS;
				r   = clip_scaled((wa <<< 31) + wb * sum);
			end
			FUNC_RESEED: begin
				gen_state = a;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("MISMATCH at %0t ns: %s: expected %h, got %h", $time, what, want, got);
		errors++;
	endtask

	// Requests are queued before results are taken, so a result beat that
	// arrives on the same edge as a new request still meets the oldest one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state = LCG_SEED;
			variate_q.delete();
			outstanding = 0;
		end else begin
			if (in_valid && !in_stall)
				variate_q.push_back(predict_variate(func, arg_a, arg_b));
			if (out_valid && !out_stall) begin
				if (variate_q.size() == 0) begin
					report_mismatch("result beat with no request outstanding", '0, value);
				end else begin
					oldest = variate_q.pop_front();
					if (value !== oldest.value)
						report_mismatch("value", oldest.value, value);
					if (saturated !== oldest.saturated)
						report_mismatch("saturated", {31'd0, oldest.saturated},
							{31'd0, saturated});
				end
			end
			outstanding = variate_q.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import lcgrv_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1950;
	localparam int LONG_HOLD = 400;
	localparam logic signed [31:0] ARG_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] ARG_MIN = 32'sh80000000;
	localparam logic signed [31:0] Q_ONE = 32'sh00010000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         func = FUNC_RAW;
	logic signed [31:0] arg_a = '0;
	logic signed [31:0] arg_b = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] value;
	logic               saturated;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit long_hold_req = 1'b0;

	lcg_random_variate_generator_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.arg_a    (arg_a),
		.arg_b    (arg_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value    (value),
		.saturated(saturated)
	);

	lcgrv_tb_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.arg_a     (arg_a),
		.arg_b     (arg_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.saturated (saturated),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [31:0] pick_arg();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6:    return $urandom_range(0, 200) - 100;
			7:          return ARG_MAX;
			8:          return ARG_MIN;
			default:    return ($urandom_range(0, 511) - 256) << 16;
		endcase
	endfunction

	task automatic send_beat(logic [2:0] f, logic signed [31:0] a, logic signed [31:0] b);
		int gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func     = f;
		arg_a    = a;
		arg_b    = b;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_beat();
		logic [2:0] f;
		logic signed [31:0] a;
		logic signed [31:0] b;
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			f = FUNC_RAW;
		else if (r < 40)
			f = FUNC_INT;
		else if (r < 60)
			f = FUNC_FIXED;
		else if (r < 85)
			f = FUNC_NORMAL;
		else if (r < 92)
			f = FUNC_RESEED;
		else
			f = 3'($urandom_range(5, 7));
		a = pick_arg();
		b = pick_arg();
		if (f == FUNC_INT && $urandom_range(0, 1))
			b = a + $urandom_range(0, 1000);
		if (f == FUNC_NORMAL && $urandom_range(0, 1))
			b = $urandom_range(0, 4 * 65536);
		send_beat(f, a, b);
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
	endtask

	// Receiver: random stall runs, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && rx_idle_en) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats: extremes, every request and the corner cases.
		send_beat(FUNC_RAW, ARG_MIN, ARG_MAX);
		send_beat(FUNC_RAW, 32'sd0, 32'sd0);
		send_beat(FUNC_INT, 32'sd0, 32'sd9);
		send_beat(FUNC_INT, -32'sd10, 32'sd10);
		send_beat(FUNC_INT, ARG_MIN, ARG_MAX);
		send_beat(FUNC_INT, ARG_MAX, ARG_MIN);
		send_beat(FUNC_INT, 32'sd5, 32'sd4);
		send_beat(FUNC_INT, ARG_MAX, ARG_MAX);
		send_beat(FUNC_INT, ARG_MIN, ARG_MIN);
		send_beat(FUNC_FIXED, 32'sd0, Q_ONE);
		send_beat(FUNC_FIXED, ARG_MIN, ARG_MAX);
		send_beat(FUNC_FIXED, ARG_MAX, ARG_MIN);
		send_beat(FUNC_FIXED, -Q_ONE, Q_ONE);
		send_beat(FUNC_NORMAL, 32'sd0, Q_ONE);
		send_beat(FUNC_NORMAL, ARG_MAX, ARG_MAX);
		send_beat(FUNC_NORMAL, ARG_MIN, ARG_MAX);
		send_beat(FUNC_NORMAL, ARG_MAX, ARG_MIN);
		send_beat(FUNC_NORMAL, Q_ONE, 32'sd0);
		send_beat(FUNC_RESEED, 32'sd0, ARG_MAX);
		send_beat(FUNC_RAW, ARG_MAX, ARG_MIN);
		send_beat(FUNC_RESEED, -32'sd1, 32'sd0);
		send_beat(FUNC_NORMAL, -Q_ONE, Q_ONE);
		send_beat(FUNC_RESEED, ARG_MIN, 32'sd0);
		send_beat(3'd5, ARG_MAX, ARG_MAX);
		send_beat(3'd6, ARG_MIN, ARG_MIN);
		send_beat(3'd7, -32'sd1, -32'sd1);
		send_beat(FUNC_RAW, 32'sd0, 32'sd0);

		// Back to back, no idling on either side.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int i = 0; i < 150; i++)
			send_random_beat();

		// The receiver holds off while the sender keeps offering beats.
		long_hold_req = 1'b1;
		for (int i = 0; i < 60; i++)
			send_random_beat();
		in_valid = 1'b0;
		wait_drained();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		for (int i = 210; i < RANDOM_ITEMS; i++) begin
			send_random_beat();
			if (i == 1000) begin
				in_valid = 1'b0;
				wait_drained();
			end
		end

		in_valid = 1'b0;
		wait_drained();
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
